// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define MCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mcc_pkg.sv -----
package mcc_pkg;

  localparam int MAX_COINS  = 16;
  localparam int MAX_TARGET = 1023;

  localparam int VALUE_W    = 10;
  localparam int ANSWER_W   = 10;
  localparam int COST_W     = 11;
  localparam int COIN_CNT_W = $clog2(MAX_COINS + 1);
  localparam int COIN_IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int TABLE_DEPTH = MAX_TARGET + 1;
  localparam int ADDR_W     = $clog2(TABLE_DEPTH);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [COST_W-1:0] UNREACHABLE = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FILL,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_coins;
    logic add_coin;
    logic load_query;
    logic start_fill;
    logic issue;
    logic write_entry;
    logic emit;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic k_done;
    logic s_last;
    logic target_skip;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/min_coin_change_dp_core.sv -----
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid / in_tready  tuser: command; tdata: coin_value, target_sum
// out_      master     out_tvalid / out_tready tdata: min_coins; tuser: impossible
//
// A clear or add request is applied at the handshake that takes it. For a query with target
// sum T and N stored coins, each sum takes one table read per coin, a fold and a write-back.
// Reset (rst_n low, synchronous) empties the coin set and the result register; the cost
// table needs no clearing, as every entry is written before it is read.
// A new request waits until the previous query has placed its answer in the result register;
// a stalled result holds a finished query back, and clear and add requests wait with it.
`include "assert_macros.svh"

module min_coin_change_dp_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mcc_pkg::IN_DATA_W-1:0]     in_tdata,   // [9:0] coin_value, [19:10] target_sum
  input  logic [1:0]                        in_tuser,   // [1:0] command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mcc_pkg::OUT_DATA_W-1:0]    out_tdata,  // [9:0] min_coins
  output logic [0:0]                        out_tuser   // [0] impossible
);

  mcc_pkg::ctrl_t               ctrl;
  mcc_pkg::status_t             status;
  logic [mcc_pkg::ANSWER_W-1:0] min_coins;
  logic                         impossible;

  // The controller sequences the request and the table fill; the datapath
  // owns the coin set, the cost table and the result register.
  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_command(in_tuser),
    .status    (status),
    .in_ready  (in_tready),
    .ctrl      (ctrl)
  );

  mcc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coin_value(in_tdata[mcc_pkg::VALUE_W-1:0]),
    .target_sum(in_tdata[2*mcc_pkg::VALUE_W-1:mcc_pkg::VALUE_W]),
    .out_ready (out_tready),
    .status    (status),
    .out_valid (out_tvalid),
    .min_coins (min_coins),
    .impossible(impossible)
  );

  assign out_tdata = {{(mcc_pkg::OUT_DATA_W-mcc_pkg::ANSWER_W){1'b0}}, min_coins};
  assign out_tuser = impossible;

  // An impossible answer always carries a zero coin count.
  `MCC_ASSERT(a_impossible_zero, out_tvalid && out_tuser[0] |-> out_tdata == '0, "impossible result with nonzero count")
  // A query holds off further requests while the table is being filled.
  `MCC_ASSERT(a_query_blocks, in_tvalid && in_tready && in_tuser == mcc_pkg::CMD_QUERY |=> !in_tready, "request taken during a query")
  // Handing over an answer always leaves a valid result on the output.
  `MCC_ASSERT(a_emit_shows, ctrl.emit |=> out_tvalid, "answer handed over but no result shown")

endmodule

// ----- hw/rtl/mcc_ram.sv -----
module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mcc_ctrl.sv -----
module mcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  mcc_pkg::status_t   status,
  output logic               in_ready,
  output mcc_pkg::ctrl_t     ctrl
);

  mcc_pkg::state_t state_r;
  mcc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mcc_pkg::command_t'(in_command))
            mcc_pkg::CMD_CLEAR: ctrl.clear_coins = 1'b1;
            mcc_pkg::CMD_ADD:   ctrl.add_coin = 1'b1;
            mcc_pkg::CMD_QUERY: begin
              ctrl.load_query = 1'b1;
              state_nxt       = mcc_pkg::ST_INIT;
            end
            default: ;
          endcase
        end
      end
      mcc_pkg::ST_INIT: begin
        ctrl.start_fill = 1'b1;
        state_nxt = status.target_skip ? mcc_pkg::ST_DONE : mcc_pkg::ST_FILL;
      end
      mcc_pkg::ST_FILL: begin
        if (status.k_done) begin
          state_nxt = mcc_pkg::ST_WRITE;
        end else begin
          ctrl.issue = 1'b1;
        end
      end
      mcc_pkg::ST_WRITE: begin
        ctrl.write_entry = 1'b1;
        state_nxt = status.s_last ? mcc_pkg::ST_DONE : mcc_pkg::ST_FILL;
      end
      mcc_pkg::ST_DONE: begin
        if (status.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = mcc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/mcc_dp.sv -----
module mcc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcc_pkg::ctrl_t                 ctrl,
  input  logic [mcc_pkg::VALUE_W-1:0]    coin_value,
  input  logic [mcc_pkg::VALUE_W-1:0]    target_sum,
  input  logic                           out_ready,
  output mcc_pkg::status_t               status,
  output logic                           out_valid,
  output logic [mcc_pkg::ANSWER_W-1:0]   min_coins,
  output logic                           impossible
);

  logic [mcc_pkg::VALUE_W-1:0]    coin_store_r [mcc_pkg::MAX_COINS];
  logic [mcc_pkg::COIN_CNT_W-1:0] coin_count_r;
  logic [mcc_pkg::VALUE_W-1:0]    target_r;
  logic [mcc_pkg::ADDR_W-1:0]     s_r;
  logic [mcc_pkg::COIN_CNT_W-1:0] k_r;
  logic [mcc_pkg::COST_W-1:0]     best_r;
  logic [mcc_pkg::COST_W-1:0]     last_r;
  logic                           rd_valid_r;
  logic                           out_valid_r;
  logic [mcc_pkg::ANSWER_W-1:0]   min_coins_r;
  logic                           impossible_r;

  logic [mcc_pkg::VALUE_W-1:0]    coin;
  logic                           coin_fits;
  logic [mcc_pkg::ADDR_W-1:0]     rd_addr;
  logic [mcc_pkg::COST_W-1:0]     rd_data;
  logic [mcc_pkg::COST_W-1:0]     cand;
  logic                           wr_en;
  logic [mcc_pkg::ADDR_W-1:0]     wr_addr;
  logic [mcc_pkg::COST_W-1:0]     wr_data;
  logic                           over_range;

  assign coin      = coin_store_r[k_r[mcc_pkg::COIN_IDX_W-1:0]];
  assign coin_fits = {{(32-mcc_pkg::VALUE_W){1'b0}}, coin}
                     <= {{(32-mcc_pkg::ADDR_W){1'b0}}, s_r};
  assign rd_addr   = s_r - mcc_pkg::ADDR_W'(coin);
  assign cand      = rd_data + mcc_pkg::COST_W'(1);

  assign wr_en   = ctrl.start_fill || ctrl.write_entry;
  assign wr_addr = ctrl.start_fill ? '0 : s_r;
  assign wr_data = ctrl.start_fill ? '0 : best_r;

  assign over_range = {{(32-mcc_pkg::VALUE_W){1'b0}}, target_r} > 32'(mcc_pkg::MAX_TARGET);

  mcc_ram #(
    .WIDTH(mcc_pkg::COST_W),
    .DEPTH(mcc_pkg::TABLE_DEPTH)
  ) u_cost_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ctrl.issue),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Coin set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= '0;
    end else if (ctrl.clear_coins) begin
      coin_count_r <= '0;
    end else if (ctrl.add_coin && coin_value != '0
                 && coin_count_r < mcc_pkg::COIN_CNT_W'(mcc_pkg::MAX_COINS)) begin
      coin_count_r <= coin_count_r + mcc_pkg::COIN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add_coin && coin_value != '0
        && coin_count_r < mcc_pkg::COIN_CNT_W'(mcc_pkg::MAX_COINS)) begin
      coin_store_r[coin_count_r[mcc_pkg::COIN_IDX_W-1:0]] <= coin_value;
    end
  end

  // Table fill: k walks the coins, s walks the sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ctrl.issue && coin_fits;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_query) begin
      target_r <= target_sum;
    end
    if (ctrl.start_fill) begin
      s_r    <= mcc_pkg::ADDR_W'(1);
      k_r    <= '0;
      best_r <= mcc_pkg::UNREACHABLE;
      last_r <= (target_r == '0) ? '0 : mcc_pkg::UNREACHABLE;
    end else if (ctrl.write_entry) begin
      s_r    <= s_r + mcc_pkg::ADDR_W'(1);
      k_r    <= '0;
      best_r <= mcc_pkg::UNREACHABLE;
      last_r <= best_r;
    end else begin
      if (ctrl.issue) begin
        k_r <= k_r + mcc_pkg::COIN_CNT_W'(1);
      end
      if (rd_valid_r && rd_data != mcc_pkg::UNREACHABLE && cand < best_r) begin
        best_r <= cand;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      if (last_r == mcc_pkg::UNREACHABLE
          || last_r > mcc_pkg::COST_W'({mcc_pkg::ANSWER_W{1'b1}})) begin
        min_coins_r  <= '0;
        impossible_r <= 1'b1;
      end else begin
        min_coins_r  <= last_r[mcc_pkg::ANSWER_W-1:0];
        impossible_r <= 1'b0;
      end
    end
  end

  assign status.k_done      = (k_r == coin_count_r);
  assign status.s_last      = ({{(32-mcc_pkg::ADDR_W){1'b0}}, s_r}
                               == {{(32-mcc_pkg::VALUE_W){1'b0}}, target_r});
  assign status.target_skip = (target_r == '0) || over_range;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign min_coins  = min_coins_r;
  assign impossible = impossible_r;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import mcc_pkg::*;

  // Command code that the block does not use; such a request must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Half period of the 12-unit clock, settling time at the end, and a
  // generous ceiling on the whole run.
  localparam int HALF_PERIOD   = 6;
  localparam int DRAIN_CYCLES  = 40;
  localparam longint RUN_LIMIT = 64'd240_000_000;

  // Target number of requests that change the block's state or ask for an answer.
  localparam int RANDOM_REQUESTS = 60;

  typedef struct packed {
    logic [ANSWER_W-1:0] min_coins;
    logic                impossible;
  } coin_answer_t;

  // Keeps a private copy of the coin set, works out the answer to every
  // accepted query and holds those answers until the block delivers them.
  class coin_answer_book;
    logic [VALUE_W-1:0] coin_store [MAX_COINS];
    int                 coin_count;
    coin_answer_t       pending_answers [$];
    int                 error_count;

    function new();
      coin_count  = 0;
      error_count = 0;
    endfunction

    task log_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
    endtask

    // Bottom-up fewest-coin table over sums 0..target.
    function coin_answer_t fewest_coins(input logic [VALUE_W-1:0] target);
      int           cost [TABLE_DEPTH];
      int           best;
      int           prev;
      int           c;
      int           answer;
      coin_answer_t result;
      cost[0] = 0;
      for (int s = 1; s <= int'(target); s++) begin
        best = int'(UNREACHABLE);
        for (int k = 0; k < coin_count; k++) begin
          c = int'(coin_store[k]);
          if (c != 0 && c <= s) begin
            prev = cost[s - c];
            if (prev != int'(UNREACHABLE) && prev + 1 < best) best = prev + 1;
          end
        end
        cost[s] = best;
      end
      answer = (int'(target) > MAX_TARGET) ? int'(UNREACHABLE) : cost[target];
      if (answer == int'(UNREACHABLE) || answer > (1 << ANSWER_W) - 1) begin
        result.min_coins  = '0;
        result.impossible = 1'b1;
      end else begin
        result.min_coins  = answer[ANSWER_W-1:0];
        result.impossible = 1'b0;
      end
      return result;
    endfunction

    // Applies an accepted request; returns 1 when the request had any effect.
    function bit note_request(input logic [1:0] cmd, input logic [VALUE_W-1:0] coin,
                              input logic [VALUE_W-1:0] target);
      case (cmd)
        CMD_CLEAR: begin
          coin_count = 0;
          return 1'b1;
        end
        CMD_ADD: begin
          if (coin == '0 || coin_count >= MAX_COINS) return 1'b0;
          coin_store[coin_count] = coin;
          coin_count++;
          return 1'b1;
        end
        CMD_QUERY: begin
          pending_answers.push_back(fewest_coins(target));
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    task check_answer(input logic [ANSWER_W-1:0] min_coins, input logic impossible);
      coin_answer_t want;
      if (pending_answers.size() == 0) begin
        log_mismatch($sformatf("unexpected answer min_coins=%0d impossible=%0b",
                               min_coins, impossible));
      end else begin
        want = pending_answers.pop_front();
        if (min_coins !== want.min_coins)
          log_mismatch($sformatf("min_coins %0d, expected %0d", min_coins, want.min_coins));
        if (impossible !== want.impossible)
          log_mismatch($sformatf("impossible %0b, expected %0b", impossible, want.impossible));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  coin_answer_book book;
  int              burst_left;
  int              useful_requests;

  always #HALF_PERIOD clk = ~clk;

  min_coin_change_dp_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [9:0] coin_value, [19:10] target_sum
    .in_tuser   (in_tuser),    // [1:0] command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [9:0] min_coins
    .out_tuser  (out_tuser)    // [0] impossible
  );

  // When stall_timer runs out the receiver picks a new behaviour: always ready, ready about
  // half the time, or ready only now and then. Changes land on the falling edge so
  // that the block sees a steady value at each rising edge.
  int stall_mode = 0;
  int stall_timer = 0;
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = 50;
    end
    stall_timer--;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Every answer handed over at a rising edge is compared with the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_answer(out_tdata[ANSWER_W-1:0], out_tuser[0]);
  end

  // Presents one request from the falling edge and holds it until the block takes
  // it. The sender works in bursts: once a burst is used up it drops tvalid for a
  // random gap. Long bursts give stretches in which the sender never idles.
  task automatic send_request(input logic [1:0] cmd, input logic [VALUE_W-1:0] coin,
                              input logic [VALUE_W-1:0] target);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {{(IN_DATA_W - 2 * VALUE_W){1'b0}}, target, coin};
    do @(posedge clk); while (!in_tready);
    if (book.note_request(cmd, coin, target)) useful_requests++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Holds the sender back until every outstanding answer has been delivered.
  task automatic pause_until_answered();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (book.pending_answers.size() != 0) @(posedge clk);
  endtask

  // Mostly small sums keep queries short; now and then the whole range is used.
  function automatic logic [VALUE_W-1:0] pick_target();
    if ($urandom_range(0, 19) == 0) return VALUE_W'($urandom_range(0, MAX_TARGET));
    return VALUE_W'($urandom_range(0, 120));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_coin();
    if ($urandom_range(0, 9) < 7) return VALUE_W'($urandom_range(1, 40));
    return VALUE_W'($urandom_range(1, 1023));
  endfunction

  initial begin
    int n_adds;
    int n_queries;
    bit paused;
    book            = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = CMD_CLEAR;
    burst_left      = 4;
    useful_requests = 0;
    paused          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. With no coins, a zero target is still reachable while any
    // other target is not; the widest target is tried on an empty set as well.
    send_request(CMD_QUERY, '0, 10'd0);
    send_request(CMD_QUERY, '0, 10'd1023);
    send_request(CMD_QUERY, '0, 10'd5);
    // A zero denomination must be dropped, and the unused command is ignored
    // even with every coin and target bit set.
    send_request(CMD_ADD, 10'd0, '0);
    send_request(CMD_UNUSED, 10'd1023, 10'd1023);
    send_request(CMD_QUERY, '0, 10'd7);
    send_request(CMD_ADD, 10'd1023, '0);
    send_request(CMD_QUERY, '0, 10'd1023);
    send_request(CMD_QUERY, '0, 10'd1022);
    send_request(CMD_CLEAR, 10'd1023, 10'd1023);
    send_request(CMD_QUERY, '0, 10'd7);
    send_request(CMD_ADD, 10'd2, '0);
    send_request(CMD_QUERY, '0, 10'd7);
    send_request(CMD_QUERY, '0, 10'd8);
    send_request(CMD_ADD, 10'd5, '0);
    send_request(CMD_QUERY, '0, 10'd7);
    // A single coin of one gives the largest possible answer.
    send_request(CMD_CLEAR, '0, '0);
    send_request(CMD_ADD, 10'd1, '0);
    send_request(CMD_QUERY, '0, 10'd1023);
    // Fill the coin set to capacity, then offer one more coin, which must be
    // ignored; the queries then run over the full set.
    send_request(CMD_CLEAR, '0, '0);
    for (int i = 0; i < 10; i++) send_request(CMD_ADD, VALUE_W'(1 << i), '0);
    foreach (book.coin_store[i]) if (i >= 10) send_request(CMD_ADD, VALUE_W'(2 * i - 17), '0);
    send_request(CMD_ADD, 10'd1000, '0);
    send_request(CMD_QUERY, '0, 10'd1023);
    send_request(CMD_QUERY, '0, 10'h2AA);
    send_request(CMD_QUERY, '0, 10'h155);
    send_request(CMD_CLEAR, '0, '0);

    // Random part. Most of it is well-formed sessions (an optional clear, a few
    // coins, a few queries); the rest is single requests with any command and any
    // data, including zero coins and the unused command.
    useful_requests = 0;
    while (useful_requests < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1)) send_request(CMD_CLEAR, VALUE_W'($urandom), VALUE_W'($urandom));
        n_adds = $urandom_range(0, 5);
        repeat (n_adds) send_request(CMD_ADD, pick_coin(), VALUE_W'($urandom));
        n_queries = $urandom_range(1, 4);
        repeat (n_queries) send_request(CMD_QUERY, VALUE_W'($urandom), pick_target());
      end else begin
        send_request(2'($urandom_range(0, 3)), VALUE_W'($urandom_range(0, 1023)), pick_target());
      end
      // Once, halfway through, the sender waits for the block to drain completely.
      if (!paused && useful_requests >= RANDOM_REQUESTS / 2) begin
        pause_until_answered();
        paused = 1'b1;
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (book.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.pending_answers.size() != 0)
      book.log_mismatch($sformatf("%0d answers never delivered", book.pending_answers.size()));
    if (book.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("[%0t] run limit reached", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
